>>> rtl/core/lwm_pkg.sv
// Shared types and constants for the LIKE wildcard matcher.
package lwm_pkg;

  localparam int MAX_CHARS_DEF = 64;

  localparam logic [7:0] ANY_RUN = 8'h25;  // '%'
  localparam logic [7:0] ANY_ONE = 8'h5F;  // '_'

  typedef enum logic [1:0] {
    OP_APPEND_PATTERN = 2'd0,
    OP_APPEND_TEXT    = 2'd1,
    OP_EVALUATE       = 2'd2,
    OP_CLEAR_PATTERN  = 2'd3
  } lwm_op_t;

  // Walker to top level: finished verdict waiting to be taken
  typedef struct packed {
    logic done;
    logic matched;
  } lwm_result_t;

endpackage

>>> rtl/core/like_wildcard_match_core.sv
// Top level of the LIKE wildcard matcher: load path, buffers, walker, result register.
//
//   channel  dir  tdata fields (lowest bit up)                       tuser
//   s_*      in   operation[1:0], char_value[9:2], zero pad [15:10]   -
//   m_*      out  matched[0], overflow[1], zero pad [7:2]             -
//
// Append and clear words are accepted back to back while the walker is idle.
// An evaluate word holds s_tready low while the walker runs: each walk step is a
// memory read (FETCH) and a decide (DECIDE), each trailing pattern char a FETCH and
// a TAIL, the final check when the text is used up a FETCH, and the walker then
// waits in DONE; the worst case grows as text length times pattern length.
// The walker sits in its done state, holding s_tready low, until the result
// register is free; a waiting result does not block loads once it is stored.
// Reset empties both buffers and clears the overflow flag; no clearing pass.
module like_wildcard_match_core
  import lwm_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // operation[1:0], char_value[9:2], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // matched[0], overflow[1], pad
);

  localparam int AW = $clog2(MAX_CHARS);
  localparam int LW = $clog2(MAX_CHARS + 1);
  localparam logic [LW-1:0] FULL = LW'(MAX_CHARS);

  logic [LW-1:0] pattern_length;
  logic [LW-1:0] text_length;
  logic          overflow_seen;
  logic          overflow_hold;

  logic          accept;
  lwm_op_t       op;
  logic [7:0]    char_value;
  logic          pat_we;
  logic          txt_we;
  logic          start;
  logic          take;
  logic          busy;
  lwm_result_t   res;
  logic [AW-1:0] pat_raddr;
  logic [AW-1:0] txt_raddr;
  logic [7:0]    pat_rdata;
  logic [7:0]    txt_rdata;

  assign s_tready   = !busy;
  assign accept     = s_tvalid && s_tready;
  assign op         = lwm_op_t'(s_tdata[1:0]);
  assign char_value = s_tdata[9:2];
  assign pat_we     = accept && (op == OP_APPEND_PATTERN) && (pattern_length != FULL);
  assign txt_we     = accept && (op == OP_APPEND_TEXT) && (text_length != FULL);
  assign start      = accept && (op == OP_EVALUATE);
  assign take       = res.done && (!m_tvalid || m_tready);

  lwm_char_ram #(.DEPTH(MAX_CHARS), .AW(AW)) u_pattern_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pattern_length[AW-1:0]),
    .wdata (char_value),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  lwm_char_ram #(.DEPTH(MAX_CHARS), .AW(AW)) u_text_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (text_length[AW-1:0]),
    .wdata (char_value),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

  lwm_walker #(.MAX_CHARS(MAX_CHARS), .AW(AW), .LW(LW)) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .plen      (pattern_length),
    .tlen      (text_length),
    .take      (take),
    .pat_rdata (pat_rdata),
    .txt_rdata (txt_rdata),
    .pat_raddr (pat_raddr),
    .txt_raddr (txt_raddr),
    .busy      (busy),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      text_length    <= '0;
      overflow_seen  <= 1'b0;
      overflow_hold  <= 1'b0;
    end else if (accept) begin
      case (op)
        OP_APPEND_PATTERN: begin
          if (pattern_length != FULL) begin
            pattern_length <= pattern_length + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        OP_APPEND_TEXT: begin
          if (text_length != FULL) begin
            text_length <= text_length + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        // walker latched the lengths; empty the text and report the flag
        OP_EVALUATE: begin
          overflow_hold <= overflow_seen;
          overflow_seen <= 1'b0;
          text_length   <= '0;
        end
        OP_CLEAR_PATTERN: begin
          pattern_length <= '0;
        end
        default: begin
          pattern_length <= pattern_length;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {6'b0, overflow_hold, res.matched};
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (pattern_length <= FULL) && (text_length <= FULL))
    else $error("buffer length past capacity");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(pat_we || txt_we))
    else $error("buffer written during walk");

  a_result_from_walker: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(res.done))
    else $error("result word without finished walk");

  a_text_emptied: assert property (@(posedge clk) disable iff (rst)
    start |=> (text_length == '0) && !overflow_seen)
    else $error("evaluate left text or overflow flag");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (res.done && !take) |=> res.done)
    else $error("verdict dropped before taken");
`endif

endmodule

>>> rtl/core/lwm_char_ram.sv
// Character buffer: one write port, one read port with registered read data.
module lwm_char_ram
  import lwm_pkg::*;
#(
  parameter int DEPTH = MAX_CHARS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lwm_walker.sv
// Greedy two-pointer LIKE walk over the pattern and text buffers.
module lwm_walker
  import lwm_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  parameter int AW        = $clog2(MAX_CHARS),
  parameter int LW        = $clog2(MAX_CHARS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [LW-1:0] plen,
  input  logic [LW-1:0] tlen,
  input  logic          take,
  input  logic [7:0]    pat_rdata,
  input  logic [7:0]    txt_rdata,
  output logic [AW-1:0] pat_raddr,
  output logic [AW-1:0] txt_raddr,
  output logic          busy,
  output lwm_result_t   result
);

  typedef enum logic [2:0] {
    IDLE,
    FETCH,
    DECIDE,
    TAIL,
    DONE
  } state_t;

  state_t        state;
  logic [LW-1:0] pi;
  logic [LW-1:0] ti;
  logic [LW-1:0] mark_p;
  logic [LW-1:0] mark_t;
  logic          have_mark;
  logic [LW-1:0] plen_q;
  logic [LW-1:0] tlen_q;
  logic          matched;

  logic pat_valid;
  logic char_hit;

  assign pat_raddr = pi[AW-1:0];
  assign txt_raddr = ti[AW-1:0];
  assign pat_valid = (pi < plen_q);
  assign char_hit  = (pat_rdata == ANY_ONE) || (pat_rdata == txt_rdata);

  assign busy           = (state != IDLE);
  assign result.done    = (state == DONE);
  assign result.matched = matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      have_mark <= 1'b0;
      matched   <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            pi        <= '0;
            ti        <= '0;
            mark_p    <= '0;
            mark_t    <= '0;
            have_mark <= 1'b0;
            plen_q    <= plen;
            tlen_q    <= tlen;
            state     <= FETCH;
          end
        end
        // addresses come straight from pi and ti; data shows up next cycle
        FETCH: begin
          if (ti < tlen_q) begin
            state <= DECIDE;
          end else if (pat_valid) begin
            state <= TAIL;
          end else begin
            matched <= 1'b1;
            state   <= DONE;
          end
        end
        DECIDE: begin
          state <= FETCH;
          if (pat_valid && pat_rdata == ANY_RUN) begin
            mark_t    <= ti;
            pi        <= pi + 1'b1;
            mark_p    <= pi + 1'b1;
            have_mark <= 1'b1;
          end else if (pat_valid && char_hit) begin
            ti <= ti + 1'b1;
            pi <= pi + 1'b1;
          end else if (have_mark) begin
            // back up to the char after the last '%', retry one text char later
            pi     <= mark_p;
            mark_t <= mark_t + 1'b1;
            ti     <= mark_t + 1'b1;
          end else begin
            matched <= 1'b0;
            state   <= DONE;
          end
        end
        // text used up: only trailing '%' may remain
        TAIL: begin
          if (pat_rdata == ANY_RUN) begin
            pi    <= pi + 1'b1;
            state <= FETCH;
          end else begin
            matched <= 1'b0;
            state   <= DONE;
          end
        end
        DONE: begin
          if (take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the LIKE wildcard matcher core.
`timescale 1ns / 100ps

module testbench;
  import lwm_pkg::*;

  localparam int DEPTH       = MAX_CHARS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_TAIL  = 40;
  localparam int RANDOM_WORDS = 150;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // operation[1:0], char_value[9:2], pad
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // matched[0], overflow[1], pad

  // Shadow copy of the matcher state
  logic [7:0] pat_buf [DEPTH];
  logic [7:0] txt_buf [DEPTH];
  int         pat_len;
  int         txt_len;
  logic       ovf_seen;

  verdict_t   verdict_q[$];
  int         errors;
  int         words_sent;
  bit         gaps_on;
  bit         stalls_on;
  int         hold_request;

  like_wildcard_match_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[like_wildcard_match_core] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Greedy two-pointer walk, back to the last '%' on a miss.
  function automatic logic text_matches();
    int ti, pi, mark_t, mark_p;
    bit have_mark;
    ti = 0;
    pi = 0;
    mark_t = 0;
    mark_p = 0;
    have_mark = 1'b0;
    while (ti < txt_len) begin
      if (pi < pat_len && pat_buf[pi] == ANY_RUN) begin
        mark_t = ti;
        pi++;
        mark_p = pi;
        have_mark = 1'b1;
      end else if (pi < pat_len && (pat_buf[pi] == ANY_ONE || pat_buf[pi] == txt_buf[ti])) begin
        ti++;
        pi++;
      end else if (have_mark) begin
        pi = mark_p;
        mark_t++;
        ti = mark_t;
      end else begin
        return 1'b0;
      end
    end
    while (pi < pat_len && pat_buf[pi] == ANY_RUN) pi++;
    return pi == pat_len;
  endfunction

  function automatic void apply_word(input lwm_op_t op, input logic [7:0] ch);
    verdict_t v;
    case (op)
      OP_APPEND_PATTERN: begin
        if (pat_len < DEPTH) begin
          pat_buf[pat_len] = ch;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      OP_APPEND_TEXT: begin
        if (txt_len < DEPTH) begin
          txt_buf[txt_len] = ch;
          txt_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      OP_EVALUATE: begin
        v.matched  = text_matches();
        v.overflow = ovf_seen;
        verdict_q.push_back(v);
        ovf_seen = 1'b0;
        txt_len  = 0;
      end
      default: begin
        pat_len = 0;
      end
    endcase
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_word(input lwm_op_t op, input logic [7:0] ch);
    int gap;
    gap = gaps_on ? pick_idle() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, ch, op};
    do @(posedge clk); while (!s_tready);
    apply_word(op, ch);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_pattern(input char_q_t chars);
    send_word(OP_CLEAR_PATTERN, 8'h00);
    foreach (chars[i]) send_word(OP_APPEND_PATTERN, chars[i]);
  endtask

  task automatic send_text_eval(input char_q_t chars);
    foreach (chars[i]) send_word(OP_APPEND_TEXT, chars[i]);
    send_word(OP_EVALUATE, 8'h00);
  endtask

  // Drop the input word first so the last one is not taken again.
  task automatic wait_for_verdicts();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_pattern_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return ANY_RUN;
    if (r < 38) return ANY_ONE;
    if (r < 85) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_text_char();
    if ($urandom_range(0, 99) < 80) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // Build a text that the pattern should accept, then maybe spoil one char.
  function automatic char_q_t text_for(input char_q_t pat);
    char_q_t t;
    int idx;
    foreach (pat[i]) begin
      if (pat[i] == ANY_RUN) begin
        repeat ($urandom_range(0, 3)) t.push_back(pick_text_char());
      end else if (pat[i] == ANY_ONE) begin
        t.push_back(pick_text_char());
      end else begin
        t.push_back(pat[i]);
      end
    end
    if (t.size() != 0 && $urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, t.size() - 1);
      if ($urandom_range(0, 1) == 0) t[idx] = pick_text_char();
      else t.delete(idx);
    end
    return t;
  endfunction

  task automatic test_directed();
    send_word(OP_EVALUATE, 8'h00);                       // empty against empty
    send_text_eval('{8'h00});                            // empty pattern, byte zero text
    send_pattern('{ANY_RUN, ANY_RUN});
    send_word(OP_EVALUATE, 8'h00);                       // empty text, only '%'
    send_text_eval('{8'hFF});
    send_pattern('{8'hFF, ANY_ONE, 8'h00});
    send_text_eval('{8'hFF, 8'h71, 8'h00});
    send_text_eval('{8'hFF, 8'h00});
    send_pattern('{ANY_RUN, 8'h62});
    send_text_eval('{8'h61, 8'h62, 8'h61, 8'h62});       // needs a backtrack
  endtask

  task automatic test_full_buffers();
    char_q_t pat;
    char_q_t txt;
    // '%' then a long run of 'a' ending in 'b': worst backtracking on all-'a' text
    pat.push_back(ANY_RUN);
    repeat (DEPTH - 2) pat.push_back(8'h61);
    pat.push_back(8'h62);
    pat.push_back(8'h63);
    pat.push_back(8'h63);                                // both dropped
    send_pattern(pat);
    repeat (DEPTH + 1) txt.push_back(8'h61);
    send_text_eval(txt);
    send_word(OP_EVALUATE, 8'h00);                       // flag cleared by the evaluate
    pat.delete();
    pat.push_back(ANY_RUN);
    repeat (DEPTH - 1) pat.push_back(ANY_ONE);
    send_pattern(pat);
    txt.delete();
    repeat (DEPTH) txt.push_back(8'($urandom_range(0, 255)));
    send_text_eval(txt);
    send_text_eval('{8'h61, 8'h62});
    // overflow survives a pattern clear
    repeat (DEPTH + 2) send_word(OP_APPEND_TEXT, 8'($urandom_range(0, 255)));
    send_word(OP_CLEAR_PATTERN, 8'h00);
    send_word(OP_EVALUATE, 8'h00);
  endtask

  task automatic test_backpressure();
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    send_pattern('{8'h61, ANY_RUN, ANY_ONE});
    hold_request = 300;
    repeat (6) send_text_eval('{8'h61, pick_text_char(), pick_text_char()});
    wait_for_verdicts();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int start;
    char_q_t pat;
    char_q_t txt;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      gaps_on   = ($urandom_range(0, 9) != 0);
      stalls_on = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3))
          send_word(lwm_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 99) < 30) begin
          pat.delete();
          repeat ($urandom_range(0, 8)) pat.push_back(pick_pattern_char());
          send_pattern(pat);
        end
        if ($urandom_range(0, 99) < 60) begin
          txt = text_for(pat);
        end else begin
          txt.delete();
          repeat ($urandom_range(0, 8)) txt.push_back(pick_text_char());
        end
        if ($urandom_range(0, 49) == 0) hold_request = $urandom_range(50, 150);
        send_text_eval(txt);
      end
    end
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        stall = stalls_on ? pick_idle() : 0;
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result word with none expected, tdata %h", m_tdata));
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.matched)
          report_mismatch($sformatf("matched expected %0b got %0b", want.matched, m_tdata[0]));
        if (m_tdata[1] !== want.overflow)
          report_mismatch($sformatf("overflow expected %0b got %0b", want.overflow, m_tdata[1]));
      end
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    pat_len      = 0;
    txt_len      = 0;
    ovf_seen     = 1'b0;
    errors       = 0;
    words_sent   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    hold_request = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_full_buffers();
    test_backpressure();
    test_random();

    stalls_on = 1'b1;
    wait_for_verdicts();
    if (errors == 0) begin
      $display("[like_wildcard_match_core] OK");
    end else begin
      $display("[like_wildcard_match_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lwm_pkg.sv
rtl/core/lwm_char_ram.sv
rtl/core/lwm_walker.sv
rtl/core/like_wildcard_match_core.sv
dv/testbench.sv
